// ===== rtl/core/ftfs_pkg.sv =====
package ftfs_pkg;

    localparam int NUM_WIDTH_DEF = 32;
    localparam int IN_WIDTH = 32;
    localparam int OUT_WIDTH = 32;
    localparam int CODE_WIDTH = 2;

    typedef enum logic [1:0] {
        CASE_SMALL = 2'd0,
        CASE_EVEN = 2'd1,
        CASE_PRIME = 2'd2,
        CASE_FERMAT = 2'd3
    } case_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic next_divisor;
        logic set_trivial;
        logic set_fermat;
        logic set_prime;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below_three;
        logic is_even;
        logic sqrt_done;
        logic div_done;
        logic rem_zero;
        logic divisor_low;
    } ctrl_stat_t;

endpackage

// ===== rtl/core/ftfs_datapath.sv =====
module ftfs_datapath #(
    parameter int NUM_WIDTH = ftfs_pkg::NUM_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic [NUM_WIDTH-1:0]           number,
    input  ftfs_pkg::ctrl_cmd_t            cmd,
    output ftfs_pkg::ctrl_stat_t           stat,
    output logic [NUM_WIDTH-1:0]           small_val,
    output logic [NUM_WIDTH-1:0]           large_val,
    output ftfs_pkg::case_code_t           code_val
);

    localparam int RW = (NUM_WIDTH + 1) / 2;
    localparam int BIT_CNT_W = $clog2(RW + 1);
    localparam int DIV_CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] n_reg;
    logic [2*RW-1:0] n_pad;
    logic [NUM_WIDTH+1:0] srem_reg, srem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [BIT_CNT_W-1:0] sbit_reg;
    logic [NUM_WIDTH-1:0] d_reg;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [NUM_WIDTH:0] drem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [NUM_WIDTH-1:0] small_reg, large_reg;
    ftfs_pkg::case_code_t code_reg;
    logic [NUM_WIDTH+1:0] trial;
    logic [NUM_WIDTH:0] dshift;
    logic [NUM_WIDTH:0] dsub;

    assign n_pad = (2*RW)'(n_reg);

    // Digit-by-digit square root, two input bits per step.
    always_comb
    begin
        srem_next = {srem_reg[NUM_WIDTH-1:0],
                     n_pad[2*(sbit_reg-1'b1)+1 -: 2]};
        trial = {{(NUM_WIDTH-RW){1'b0}}, root_reg, 2'b01};
        if (srem_next >= trial)
        begin
            srem_next = srem_next - trial;
            root_next = {root_reg[RW-2:0], 1'b1};
        end
        else
        begin
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    // Restoring division, one quotient bit per step.
    always_comb
    begin
        dshift = {drem_reg[NUM_WIDTH-1:0], quo_reg[NUM_WIDTH-1]};
        dsub = dshift - {1'b0, d_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= number;
            srem_reg <= '0;
            root_reg <= '0;
            sbit_reg <= BIT_CNT_W'(RW);
        end
        else if (cmd.sqrt_step)
        begin
            srem_reg <= srem_next;
            root_reg <= root_next;
            sbit_reg <= sbit_reg - 1'b1;
        end
        if (cmd.sqrt_step && sbit_reg == BIT_CNT_W'(1))
        begin
            d_reg <= NUM_WIDTH'(root_next);
        end
        else if (cmd.next_divisor)
        begin
            d_reg <= d_reg - 1'b1;
        end
        if (cmd.div_start)
        begin
            quo_reg <= n_reg;
            drem_reg <= '0;
            dcnt_reg <= DIV_CNT_W'(NUM_WIDTH);
        end
        else if (cmd.div_step)
        begin
            if (!dsub[NUM_WIDTH])
            begin
                drem_reg <= dsub;
                quo_reg <= {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift;
                quo_reg <= {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.set_trivial)
        begin
            if (n_reg < NUM_WIDTH'(3))
            begin
                small_reg <= NUM_WIDTH'(1);
                large_reg <= n_reg;
                code_reg <= ftfs_pkg::CASE_SMALL;
            end
            else
            begin
                small_reg <= NUM_WIDTH'(2);
                large_reg <= n_reg >> 1;
                code_reg <= ftfs_pkg::CASE_EVEN;
            end
        end
        else if (cmd.set_fermat)
        begin
            small_reg <= d_reg;
            large_reg <= quo_reg;
            code_reg <= ftfs_pkg::CASE_FERMAT;
        end
        else if (cmd.set_prime)
        begin
            small_reg <= NUM_WIDTH'(1);
            large_reg <= n_reg;
            code_reg <= ftfs_pkg::CASE_PRIME;
        end
    end

    assign stat.below_three = (n_reg < NUM_WIDTH'(3));
    assign stat.is_even = ~n_reg[0];
    assign stat.sqrt_done = (sbit_reg == BIT_CNT_W'(1));
    assign stat.div_done = (dcnt_reg == DIV_CNT_W'(0));
    assign stat.rem_zero = (drem_reg == '0);
    assign stat.divisor_low = (d_reg < NUM_WIDTH'(2));
    assign small_val = small_reg;
    assign large_val = large_reg;
    assign code_val = code_reg;

endmodule

// ===== rtl/core/ftfs_ctrl.sv =====
module ftfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ftfs_pkg::ctrl_stat_t  stat,
    output ftfs_pkg::ctrl_cmd_t   cmd
);

    ftfs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ftfs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ftfs_pkg::ST_SQRT;
                end
            end
            ftfs_pkg::ST_SQRT:
            begin
                if (stat.below_three || stat.is_even)
                begin
                    cmd.set_trivial = 1'b1;
                    state_next = ftfs_pkg::ST_DONE;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    if (stat.sqrt_done)
                    begin
                        state_next = ftfs_pkg::ST_DIV_START;
                    end
                end
            end
            ftfs_pkg::ST_DIV_START:
            begin
                if (stat.divisor_low)
                begin
                    cmd.set_prime = 1'b1;
                    state_next = ftfs_pkg::ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ftfs_pkg::ST_DIV_WAIT;
                end
            end
            ftfs_pkg::ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.set_fermat = 1'b1;
                        state_next = ftfs_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.next_divisor = 1'b1;
                        state_next = ftfs_pkg::ST_DIV_START;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ftfs_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ftfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftfs_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is offered only after the input side has closed.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output open together");
    // A result is offered only after an input transaction was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftfs_pkg::ST_IDLE && in_valid) |=> !out_valid)
        else $error("result offered in the cycle after accept");
    // Division starts only with a divisor of at least two.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.divisor_low)
        else $error("division by a divisor below two");

endmodule

// ===== rtl/core/fermat_two_factor_split_unit.sv =====
// Channel | Signals                             | Direction | Content
// s_axis  | s_axis_tvalid/tready/tdata[31:0]    | in        | number
// m_axis  | m_axis_tvalid/tready/tdata[71:0]    | out       | small, large, case code
// One item is in work at a time; a new one is taken after the result leaves.
// Values below three and even values skip the square root and go straight to the result.
// Odd values take (NUM_WIDTH+1)/2 square root steps, then one full division
// for each trial divisor, scanned downward from the integer square root.
// Reset clears only the controller; a stalled result holds until taken.
module fermat_two_factor_split_unit #(
    parameter int NUM_WIDTH = ftfs_pkg::NUM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // small_factor, large_factor, case_code, zeros
);

    ftfs_pkg::ctrl_cmd_t cmd;
    ftfs_pkg::ctrl_stat_t stat;
    logic [NUM_WIDTH-1:0] small_val, large_val;
    ftfs_pkg::case_code_t code_val;

    ftfs_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .stat(stat),
        .cmd(cmd)
    );

    ftfs_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .clk(clk),
        .number(NUM_WIDTH'(s_axis_tdata)),
        .cmd(cmd),
        .stat(stat),
        .small_val(small_val),
        .large_val(large_val),
        .code_val(code_val)
    );

    assign m_axis_tdata = {6'd0, code_val, 32'(large_val), 32'(small_val)};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    class split_scoreboard;
        logic [65:0] expected_q[$];
        int errors;
        int checked;
        int per_case[4];

        function logic [31:0] int_sqrt(logic [63:0] n);
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bit_v;
            rem = n;
            root = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > rem)
                bit_v = bit_v >> 2;
            while (bit_v != 0)
            begin
                if (rem >= root + bit_v)
                begin
                    rem = rem - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end
                else
                    root = root >> 1;
                bit_v = bit_v >> 2;
            end
            return root[31:0];
        endfunction

        function logic [65:0] split_number(logic [31:0] num);
            logic [63:0] n;
            logic [63:0] d;
            logic [31:0] lo;
            logic [31:0] hi;
            ftfs_pkg::case_code_t code;
            n = {32'd0, num};
            lo = 32'd1;
            hi = num;
            if (n < 3)
                code = ftfs_pkg::CASE_SMALL;
            else if (num[0] == 1'b0)
            begin
                lo = 32'd2;
                hi = num >> 1;
                code = ftfs_pkg::CASE_EVEN;
            end
            else
            begin
                code = ftfs_pkg::CASE_PRIME;
                for (d = int_sqrt(n); d >= 2; d--)
                begin
                    if (n % d == 0)
                    begin
                        lo = d[31:0];
                        hi = 32'(n / d);
                        code = ftfs_pkg::CASE_FERMAT;
                        break;
                    end
                end
            end
            return {code, hi, lo};
        endfunction

        function void note_number(logic [31:0] num);
            expected_q.push_back(split_number(num));
        endfunction

        function void check_split(logic [71:0] data);
            logic [65:0] exp_v;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: %h", data);
                return;
            end
            exp_v = expected_q.pop_front();
            checked++;
            per_case[exp_v[65:64]]++;
            if (data[31:0] !== exp_v[31:0] || data[63:32] !== exp_v[63:32]
                || data[65:64] !== exp_v[65:64])
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: small %0d/%0d large %0d/%0d case %0d/%0d (exp/act)",
                             exp_v[31:0], data[31:0], exp_v[63:32], data[63:32],
                             exp_v[65:64], data[65:64]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    split_scoreboard sb;
    int burst_left;
    int stall_mode = 0;
    int stall_cnt = 0;

    fermat_two_factor_split_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_number(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_split(m_axis_tdata);
        end
    end

    // The receiver alternates between runs of full acceptance and runs of random stalls.
    always @(posedge clk)
    begin
        if (stall_cnt == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_cnt <= $urandom_range(5, 60);
        end
        else
            stall_cnt <= stall_cnt - 1;
        if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_number(logic [31:0] num);
        logic hs;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= num;
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_number();
        logic [63:0] prod;
        logic [31:0] d;
        logic [31:0] e;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return $urandom & 32'hFFFF_FFFE;
        if (sel < 40)
            return $urandom_range(0, 2);
        if (sel < 60)
            return $urandom_range(3, 9999) | 32'd1;
        // Odd composite whose factors lie close to the square root.
        do
        begin
            d = $urandom_range(3, 65535) | 32'd1;
            e = d + 2 * $urandom_range(0, 100);
            prod = d * e;
        end
        while (prod > 64'hFFFF_FFFF);
        return prod[31:0];
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd21,
                     32'd25, 32'd97, 32'd7919, 32'd9999, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                     32'h8000_0000, 32'hFFFE_0001, 32'h5555_5554, 32'hAAAA_AAAA,
                     32'd1_000_001};
        foreach (directed[i])
            send_number(directed[i]);
        wait_drained();
        for (int i = 0; i < 100; i++)
            send_number(random_number());
        wait_drained();
        repeat (50) @(posedge clk);
        $display("Checked %0d transactions: %0d below three, %0d even, %0d prime, %0d split.",
                 sb.checked, sb.per_case[0], sb.per_case[1], sb.per_case[2], sb.per_case[3]);
        $display("Receiver stalls and sender gaps were randomized; mismatches: %0d.", sb.errors);
        if (sb.errors == 0)
            $display("[fermat_two_factor_split_unit] OK");
        else
            $display("[fermat_two_factor_split_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[fermat_two_factor_split_unit] ERROR");
        $finish;
    end

endmodule
